FILE: rtl/s0pwq_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s0pwq_pkg
// Shared types and constants of the S0 pulse-width qualified counter.
// ----------------------------------------------------------------------------
package s0pwq_pkg;

    localparam int SLOTS     = 8;
    localparam int DUR_W     = 8;
    localparam int CNT_W     = 32;
    localparam int LEN_W     = SLOTS * DUR_W;
    localparam int CFG_IDX_W = 8;
    localparam int CFG_DAT_W = 64;
    localparam int S_DATA_W  = 8;
    localparam int M_DATA_W  = SLOTS + SLOTS * CNT_W;

    localparam logic [DUR_W-1:0] DUR_MAX = {DUR_W{1'b1}};

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_ENABLE_MASK = 8'd0,
        REG_MIN_LENGTHS = 8'd1,
        REG_MAX_LENGTHS = 8'd2
    } cfg_reg_t;

    typedef struct packed {
        logic             enable;
        logic [DUR_W-1:0] min_len;
        logic [DUR_W-1:0] max_len;
    } lane_cfg_t;

endpackage

FILE: rtl/s0pwq_lane.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s0pwq_lane
// One channel: low-level duration counter, width qualification, pulse total.
// ----------------------------------------------------------------------------
module s0pwq_lane (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       step,
    input  logic                       level,
    input  s0pwq_pkg::lane_cfg_t       cfg,
    output logic                       hit,
    output logic [s0pwq_pkg::CNT_W-1:0] total
);
    import s0pwq_pkg::*;

    logic [DUR_W-1:0] dur_reg, dur_next;
    logic [CNT_W-1:0] total_reg, total_next;

    assign hit = cfg.enable && level && (dur_reg != '0) &&
                 (dur_reg > cfg.min_len) && (dur_reg < cfg.max_len);

    always_comb begin
        dur_next   = dur_reg;
        total_next = total_reg;
        if (step && cfg.enable) begin
            if (!level) begin
                if (dur_reg != DUR_MAX) begin
                    dur_next = dur_reg + 1'b1;
                end
            end else begin
                dur_next = '0;
                if (hit) begin
                    total_next = total_reg + 1'b1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            dur_reg   <= '0;
            total_reg <= '0;
        end else begin
            dur_reg   <= dur_next;
            total_reg <= total_next;
        end
    end

    assign total = total_reg;

endmodule

FILE: rtl/s0pwq_merge.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s0pwq_merge
// Gathers lane hits into the pulse mask and holds the result item.
// ----------------------------------------------------------------------------
module s0pwq_merge (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    input  logic                                   step,
    input  logic [s0pwq_pkg::SLOTS-1:0]            hits,
    input  logic [s0pwq_pkg::SLOTS*s0pwq_pkg::CNT_W-1:0] totals,
    output logic                                   slot_free,
    output logic                                   m_tvalid,
    input  logic                                   m_tready,
    output logic [s0pwq_pkg::M_DATA_W-1:0]         m_tdata
);
    import s0pwq_pkg::*;

    logic             valid_reg, valid_next;
    logic [SLOTS-1:0] mask_reg, mask_next;

    assign slot_free = !valid_reg || m_tready;

    always_comb begin
        valid_next = valid_reg;
        mask_next  = mask_reg;
        if (step) begin
            valid_next = 1'b1;
            mask_next  = hits;
        end else if (m_tready) begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        mask_reg <= mask_next;
    end

    // totals live in the lanes and only move when the output slot turns over
    assign m_tvalid = valid_reg;
    assign m_tdata  = {totals, mask_reg};

endmodule

FILE: rtl/s0_pulse_width_qualified_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s0_pulse_width_qualified_counter
// Eight-channel S0 meter pulse counter with per-channel width qualification.
// ----------------------------------------------------------------------------
// Usage:
//   s_ channel: one item per poll tick, s_tdata = pin levels, bit n channel n.
//   m_ channel: one item per input item, m_tdata = pulse mask [7:0], then the
//     32-bit wrapping totals of channels 0..7 from bit 8 up.
//   cfg channel: register index and 64-bit data, always ready outside reset;
//     index 0 enable mask, 1 min lengths, 2 max lengths, others ignored.
//   Result item registered and valid in the cycle after the input item; one
//   item per cycle while m_tready is high, set by the single merge register.
//   Each present channel is a lane of its own, enabled ones updated in the cycle of the item.
//   Reset clears duration counters, totals, registers and the output slot.
//   When the receiver stalls the result item is held and s_tready drops
//   until it is taken; s_tready returns in the same cycle as m_tready.
// ----------------------------------------------------------------------------
module s0_pulse_width_qualified_counter #(
    parameter int NUM_CHANNELS = 8
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  s_tvalid,
    output logic                                  s_tready,
    input  logic [s0pwq_pkg::S_DATA_W-1:0]        s_tdata,  // [7:0] pin_levels
    output logic                                  m_tvalid,
    input  logic                                  m_tready,
    // [7:0] pulse_mask, then count_ch0..count_ch7 at 32 bits each
    output logic [s0pwq_pkg::M_DATA_W-1:0]        m_tdata,
    input  logic                                  cfg_valid,
    output logic                                  cfg_ready,
    input  logic [s0pwq_pkg::CFG_IDX_W-1:0]       cfg_index,
    input  logic [s0pwq_pkg::CFG_DAT_W-1:0]       cfg_data
);
    import s0pwq_pkg::*;

    logic [SLOTS-1:0] enable_reg, enable_next;
    logic [LEN_W-1:0] min_reg, min_next;
    logic [LEN_W-1:0] max_reg, max_next;

    logic                   slot_free;
    logic                   step;
    logic [SLOTS-1:0]       hits;
    logic [SLOTS*CNT_W-1:0] totals;

    assign cfg_ready = aresetn;
    assign s_tready  = aresetn && slot_free;
    assign step      = s_tvalid && s_tready;

    always_comb begin
        enable_next = enable_reg;
        min_next    = min_reg;
        max_next    = max_reg;
        if (cfg_valid && cfg_ready) begin
            unique case (cfg_index)
                REG_ENABLE_MASK: enable_next = cfg_data[SLOTS-1:0];
                REG_MIN_LENGTHS: min_next    = cfg_data[LEN_W-1:0];
                REG_MAX_LENGTHS: max_next    = cfg_data[LEN_W-1:0];
                default: ;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            enable_reg <= '0;
            min_reg    <= '0;
            max_reg    <= '0;
        end else begin
            enable_reg <= enable_next;
            min_reg    <= min_next;
            max_reg    <= max_next;
        end
    end

    for (genvar n = 0; n < SLOTS; n++) begin : g_lane
        if (n < NUM_CHANNELS) begin : g_on
            lane_cfg_t lcfg;

            assign lcfg.enable  = enable_reg[n];
            assign lcfg.min_len = min_reg[n*DUR_W +: DUR_W];
            assign lcfg.max_len = max_reg[n*DUR_W +: DUR_W];

            s0pwq_lane u_lane (
                .aclk    (aclk),
                .aresetn (aresetn),
                .step    (step),
                .level   (s_tdata[n]),
                .cfg     (lcfg),
                .hit     (hits[n]),
                .total   (totals[n*CNT_W +: CNT_W])
            );
        end else begin : g_off
            assign hits[n]                  = 1'b0;
            assign totals[n*CNT_W +: CNT_W] = '0;
        end
    end

    s0pwq_merge u_merge (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .step      (step),
        .hits      (hits),
        .totals    (totals),
        .slot_free (slot_free),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata)
    );

endmodule

FILE: rtl/s0pwq_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// s0pwq_checker
// Port-level checks of the pulse counter, bound to the top level.
// ----------------------------------------------------------------------------
module s0pwq_checker #(
    parameter int NUM_CHANNELS = 8
) (
    input logic                           aclk,
    input logic                           aresetn,
    input logic                           s_tvalid,
    input logic                           s_tready,
    input logic                           m_tvalid,
    input logic                           m_tready,
    input logic [s0pwq_pkg::M_DATA_W-1:0] m_tdata
);
    import s0pwq_pkg::*;

    localparam logic [SLOTS-1:0] LIVE = SLOTS'((1 << NUM_CHANNELS) - 1);

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata))
        else $error("result item changed while stalled");

    a_ready_when_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        !m_tvalid |-> s_tready)
        else $error("input stalled with empty output slot");

    a_item_out: assert property (@(posedge aclk) disable iff (!aresetn)
        s_tvalid && s_tready |=> m_tvalid)
        else $error("accepted item gave no result item");

    a_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && m_tready && !(s_tvalid && s_tready) |=> !m_tvalid)
        else $error("result item repeated");

    a_absent: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata[SLOTS-1:0] & ~LIVE) == '0)
        else $error("pulse reported on absent channel");

endmodule

bind s0_pulse_width_qualified_counter s0pwq_checker #(
    .NUM_CHANNELS (NUM_CHANNELS)
) u_s0pwq_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
